### src/tms_pkg.sv
// tms_pkg: shared types and constants for the timestamp merge selector
// lane status codes, request codes and the structs passed between modules
// no dependencies
package tms_pkg;

	localparam int LANE_W = 3;
	localparam int TIME_W = 64;
	localparam int CFG_W  = 4;

	localparam logic REQ_HEAD = 1'b0;
	localparam logic REQ_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_HOLD  = 2'd1,
		ST_ENDED = 2'd2
	} lane_st_t;

	// one item applied to the lane store
	typedef struct packed {
		logic              apply;
		logic              is_end;
		logic [LANE_W-1:0] lane;
		logic [TIME_W-1:0] rtime;
	} lane_upd_t;

	// outcome of the selection for the current item
	typedef struct packed {
		logic              emit;
		logic              done;
		logic [LANE_W-1:0] lane;
		logic [TIME_W-1:0] rtime;
	} sel_t;

endpackage

### src/tms_lane_store.sv
// tms_lane_store: per-lane status and head timestamp registers
// applies one item and the selection outcome per beat; uses tms_pkg
module tms_lane_store import tms_pkg::*; #(
	parameter int NUM_HEAD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lane_upd_t         upd,
	input  logic [CFG_W-1:0]  n_eff,
	input  sel_t              sel,
	output lane_st_t          status_post [NUM_HEAD],
	output logic [TIME_W-1:0] head_post   [NUM_HEAD]
);

	lane_st_t          status_q [NUM_HEAD];
	logic [TIME_W-1:0] head_q   [NUM_HEAD];
	logic              lane_ok;

	// item only counts when its lane is inside the active count
	assign lane_ok = ({1'b0, upd.lane} < n_eff);

	// state as seen after this item lands
	always_comb begin
		for (int i = 0; i < NUM_HEAD; i++) begin
			status_post[i] = status_q[i];
			head_post[i]   = head_q[i];
			if (upd.apply && lane_ok && upd.lane == LANE_W'(i) && status_q[i] == ST_EMPTY) begin
				if (upd.is_end == REQ_END) begin
					status_post[i] = ST_ENDED;
				end else begin
					status_post[i] = ST_HOLD;
					head_post[i]   = upd.rtime;
				end
			end
		end
	end

	// status: apply the item, then empty the chosen lane, or re-arm all on a done result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HEAD; i++) status_q[i] <= ST_EMPTY;
		end else if (upd.apply) begin
			for (int i = 0; i < NUM_HEAD; i++) begin
				if (sel.emit && sel.done)
					status_q[i] <= ST_EMPTY;
				else if (sel.emit && sel.lane == LANE_W'(i))
					status_q[i] <= ST_EMPTY;
				else
					status_q[i] <= status_post[i];
			end
		end
	end

	// head timestamps, payload only
	always_ff @(posedge clk) begin
		if (upd.apply) begin
			for (int i = 0; i < NUM_HEAD; i++) head_q[i] <= head_post[i];
		end
	end

endmodule

### src/tms_selector.sv
// tms_selector: readiness check and smallest-timestamp compare tree
// combinational, works on the post-update lane state; uses tms_pkg
module tms_selector import tms_pkg::*; #(
	parameter int NUM_HEAD = 8
) (
	input  lane_st_t          status_post [NUM_HEAD],
	input  logic [TIME_W-1:0] head_post   [NUM_HEAD],
	input  logic [CFG_W-1:0]  n_eff,
	output sel_t              sel
);

	localparam int IDX_W  = (NUM_HEAD > 1) ? $clog2(NUM_HEAD) : 1;
	localparam int LEAVES = 2 ** IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic              any_empty;
	logic              nv [NODES];
	logic [IDX_W-1:0]  ni [NODES];
	logic [TIME_W-1:0] nt [NODES];

	// every active lane must hold a head or have ended
	always_comb begin
		// lanes past the addressable range can never be filled
		any_empty = (int'(n_eff) > NUM_HEAD);
		for (int i = 0; i < NUM_HEAD; i++) begin
			if (i < int'(n_eff) && status_post[i] == ST_EMPTY) any_empty = 1'b1;
		end
	end

	// compare tree, left child wins ties so the lower lane is kept
	always_comb begin
		for (int k = 0; k < LEAVES; k++) begin
			if (k < NUM_HEAD) begin
				nv[LEAVES-1+k] = (k < int'(n_eff)) && (status_post[k] == ST_HOLD);
				nt[LEAVES-1+k] = head_post[k];
			end else begin
				nv[LEAVES-1+k] = 1'b0;
				nt[LEAVES-1+k] = '0;
			end
			ni[LEAVES-1+k] = IDX_W'(k);
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (nv[2*k+1] && (!nv[2*k+2] || nt[2*k+1] <= nt[2*k+2])) begin
				nv[k] = 1'b1;
				ni[k] = ni[2*k+1];
				nt[k] = nt[2*k+1];
			end else begin
				nv[k] = nv[2*k+2];
				ni[k] = ni[2*k+2];
				nt[k] = nt[2*k+2];
			end
		end
	end

	// result: a chosen head, or done when nothing holds
	always_comb begin
		sel.emit  = !any_empty;
		sel.done  = !nv[0];
		sel.lane  = nv[0] ? LANE_W'(ni[0]) : '0;
		sel.rtime = nv[0] ? nt[0] : '0;
	end

endmodule

### src/timestamp_merge_selector.sv
// timestamp_merge_selector: k-way merge of per-lane sorted streams by timestamp
// input register, then combinational lane update and 64-bit compare tree, then result register
// throughput: one input beat per cycle while the result register is free or being taken
// an input beat causes zero or one result beat; the result register frees as it is taken
// reset (arst_n low): all lanes empty, active lane count 1, both pipeline registers empty
// uses tms_pkg, tms_lane_store, tms_selector
module timestamp_merge_selector import tms_pkg::*; #(
	parameter int MAX_LANES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [LANE_W-1:0] lane,
	input  logic [TIME_W-1:0] record_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LANE_W-1:0] chosen_lane,
	output logic [TIME_W-1:0] chosen_time,
	output logic              round_done
);

	// only lanes reachable through the lane field get storage
	localparam int NUM_HEAD = (MAX_LANES < (2 ** LANE_W)) ? MAX_LANES : (2 ** LANE_W);

	logic [CFG_W-1:0]  active_q;
	logic [CFG_W-1:0]  n_eff;
	logic              s1_valid_q;
	logic              req_type_s1;
	logic [LANE_W-1:0] lane_s1;
	logic [TIME_W-1:0] time_s1;
	logic              s1_fire;
	logic              out_valid_q;
	logic [LANE_W-1:0] lane_q;
	logic [TIME_W-1:0] time_q;
	logic              done_q;
	lane_upd_t         upd;
	sel_t              sel;
	lane_st_t          status_post [NUM_HEAD];
	logic [TIME_W-1:0] head_post   [NUM_HEAD];

	// active lane count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(1);
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// effective count: zero reads as one, saturate at MAX_LANES
	always_comb begin
		if (active_q == '0)
			n_eff = CFG_W'(1);
		else if (int'(active_q) > MAX_LANES)
			n_eff = CFG_W'(MAX_LANES);
		else
			n_eff = active_q;
	end

	// the input stage moves on whenever the result register can take its outcome
	assign s1_fire  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			lane_s1     <= lane;
			time_s1     <= record_time;
		end
	end

	always_comb begin
		upd.apply  = s1_fire;
		upd.is_end = req_type_s1;
		upd.lane   = lane_s1;
		upd.rtime  = time_s1;
	end

	tms_lane_store #(
		.NUM_HEAD(NUM_HEAD)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.n_eff      (n_eff),
		.sel        (sel),
		.status_post(status_post),
		.head_post  (head_post)
	);

	tms_selector #(
		.NUM_HEAD(NUM_HEAD)
	) u_sel (
		.status_post(status_post),
		.head_post  (head_post),
		.n_eff      (n_eff),
		.sel        (sel)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= sel.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && sel.emit) begin
			lane_q <= sel.lane;
			time_q <= sel.rtime;
			done_q <= sel.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_lane = lane_q;
	assign chosen_time = time_q;
	assign round_done  = done_q;

	// a done beat carries no lane and no timestamp
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && round_done |-> chosen_lane == '0 && chosen_time == '0)
		else $error("done beat with nonzero lane or time");

	// after a done outcome every lane is re-armed; checked on lane 0 while no new beat is applied
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && sel.emit && sel.done |=> status_post[0] == ST_EMPTY || s1_fire)
		else $error("lane 0 not re-armed after done");

	// a chosen record always comes from an active lane
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && sel.emit && !sel.done |-> {1'b0, sel.lane} < n_eff)
		else $error("chosen lane outside active count");

	// input stalls only while the input register holds a waiting beat
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid_q && out_valid_q && !out_ready)
		else $error("input stalled without cause");

endmodule

### tb/tms_merge_checker.sv
// tms_merge_checker: watches the input, config and result channels of the merge selector,
// predicts each result beat from its own lane model and compares it field by field
// depends on tms_pkg for widths, request codes and lane status codes
module tms_merge_checker import tms_pkg::*; #(
	parameter int MAX_LANES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              req_type,
	input  logic [LANE_W-1:0] lane,
	input  logic [TIME_W-1:0] record_time,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [LANE_W-1:0] chosen_lane,
	input  logic [TIME_W-1:0] chosen_time,
	input  logic              round_done,
	output int                fail_count,
	output int                pending,
	output logic              lanes_clear
);

	typedef struct packed {
		logic              done;
		logic [LANE_W-1:0] lane;
		logic [TIME_W-1:0] rtime;
	} pick_t;

	pick_t             due_picks[$];
	lane_st_t          lane_st [MAX_LANES];
	logic [TIME_W-1:0] lane_head [MAX_LANES];
	int                live_lanes;
	int                errors;

	// apply one input beat to the lane model, queue the pick it causes if any
	function automatic void predict_pick(logic kind, logic [LANE_W-1:0] ln,
			logic [TIME_W-1:0] t);
		int i;
		int best;
		logic found;
		logic any_empty;
		pick_t p;
		best = 0;
		found = 1'b0;
		any_empty = 1'b0;
		if (int'(ln) < live_lanes && lane_st[ln] == ST_EMPTY) begin
			if (kind == REQ_END) begin
				lane_st[ln] = ST_ENDED;
			end else begin
				lane_head[ln] = t;
				lane_st[ln] = ST_HOLD;
			end
		end
		for (i = 0; i < live_lanes; i++)
			if (lane_st[i] == ST_EMPTY)
				any_empty = 1'b1;
		if (any_empty)
			return;
		// smallest head wins, lowest lane on ties
		for (i = 0; i < live_lanes; i++) begin
			if (lane_st[i] == ST_HOLD) begin
				if (!found || lane_head[i] < lane_head[best]) begin
					best = i;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			p.done = 1'b0;
			p.lane = LANE_W'(best);
			p.rtime = lane_head[best];
			lane_st[best] = ST_EMPTY;
		end else begin
			// every live lane ended: round done, re-arm all lanes
			p.done = 1'b1;
			p.lane = '0;
			p.rtime = '0;
			for (i = 0; i < MAX_LANES; i++)
				lane_st[i] = ST_EMPTY;
		end
		due_picks.push_back(p);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pick_t want;
		logic all_empty;
		int i;
		if (!arst_n) begin
			for (i = 0; i < MAX_LANES; i++) begin
				lane_st[i] = ST_EMPTY;
				lane_head[i] = '0;
			end
			live_lanes = 1;
			errors = 0;
			due_picks.delete();
			fail_count <= 0;
			pending <= 0;
			lanes_clear <= 1'b1;
		end else begin
			// result beat against the oldest expected pick
			if (out_valid && out_ready) begin
				if (due_picks.size() == 0) begin
					$display("%0t: unexpected result beat: lane %0d time %h done %b",
						$time, chosen_lane, chosen_time, round_done);
					errors++;
				end else begin
					want = due_picks.pop_front();
					if (chosen_lane !== want.lane) begin
						$display("%0t: chosen_lane expected %0d actual %0d",
							$time, want.lane, chosen_lane);
						errors++;
					end
					if (chosen_time !== want.rtime) begin
						$display("%0t: chosen_time expected %h actual %h",
							$time, want.rtime, chosen_time);
						errors++;
					end
					if (round_done !== want.done) begin
						$display("%0t: round_done expected %b actual %b",
							$time, want.done, round_done);
						errors++;
					end
				end
			end
			// input beat through the model
			if (in_valid && in_ready)
				predict_pick(req_type, lane, record_time);
			// lane count write, zero counts as one, saturates at the lane total
			if (cfg_we) begin
				if (cfg_wdata == '0)
					live_lanes = 1;
				else if (int'(cfg_wdata) > MAX_LANES)
					live_lanes = MAX_LANES;
				else
					live_lanes = int'(cfg_wdata);
			end
			all_empty = 1'b1;
			for (i = 0; i < live_lanes; i++)
				if (lane_st[i] != ST_EMPTY)
					all_empty = 1'b0;
			fail_count <= errors;
			pending <= due_picks.size();
			lanes_clear <= all_empty;
		end
	end

endmodule

### tb/tb_timestamp_merge_selector.sv
// tb_timestamp_merge_selector: stimulus and verdict for the timestamp merge selector
// drives planned merge rounds, noise and lane-count changes under several idle mixes
// depends on tms_pkg, timestamp_merge_selector and tms_merge_checker
module tb_timestamp_merge_selector;
	import tms_pkg::*;

	localparam int TB_LANES    = 8;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 120;
	localparam int NUM_PHASES  = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              req_type = 1'b0;
	logic [LANE_W-1:0] lane = '0;
	logic [TIME_W-1:0] record_time = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [LANE_W-1:0] chosen_lane;
	logic [TIME_W-1:0] chosen_time;
	logic              round_done;

	int   fail_count;
	int   pending;
	logic lanes_clear;

	int   cycles = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count = 0;
	int   items_sent = 0;
	int   rounds = 0;

	int   lane_settings [NUM_PHASES] = '{3, 8, 0, 15, 2, 5, 1, 7, 4, 6};

	// per-lane plan for one merge round
	logic [TIME_W-1:0] plan_time [TB_LANES][6];
	int                plan_len [TB_LANES];
	int                plan_pos [TB_LANES];
	int                fill_order [TB_LANES];

	timestamp_merge_selector u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.lane        (lane),
		.record_time (record_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chosen_lane (chosen_lane),
		.chosen_time (chosen_time),
		.round_done  (round_done)
	);

	tms_merge_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.lane        (lane),
		.record_time (record_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chosen_lane (chosen_lane),
		.chosen_time (chosen_time),
		.round_done  (round_done),
		.fail_count  (fail_count),
		.pending     (pending),
		.lanes_clear (lanes_clear)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold once requested
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			if (hold_count == LONG_HOLD - 1)
				hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// offer one beat, with random idle cycles ahead of it, until accepted
	task automatic push_item(input logic kind, input logic [LANE_W-1:0] ln,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		lane <= ln;
		record_time <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// stop offering and wait until every expected result beat has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// lane count write while the block is idle
	task automatic set_lane_count(input int v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// end lanes one by one until the model reports every live lane empty
	task automatic clear_lanes(input int n);
		int ln;
		ln = 0;
		wait_drained();
		while (!lanes_clear) begin
			push_item(REQ_END, LANE_W'(ln), '0);
			ln = (ln + 1) % n;
			wait_drained();
		end
	endtask

	// next planned beat of a lane: its current head, or the end mark
	task automatic offer_lane(input int l);
		if (plan_pos[l] < plan_len[l])
			push_item(REQ_HEAD, LANE_W'(l), plan_time[l][plan_pos[l]]);
		else
			push_item(REQ_END, LANE_W'(l), {$urandom, $urandom});
	endtask

	// one well-formed round: sorted heads per lane, refilled in merge order
	task automatic run_round(input int n);
		int i;
		int j;
		int best;
		int mode;
		int ln;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] nxt;
		mode = $urandom_range(2);
		for (i = 0; i < n; i++) begin
			plan_len[i] = $urandom_range(5);
			plan_pos[i] = 0;
			fill_order[i] = i;
			case (mode)
				0: t = 64'($urandom_range(3));
				1: t = {$urandom, $urandom};
				default: t = {40'hFF_FFFF_FFFF, 24'($urandom)};
			endcase
			for (j = 0; j < plan_len[i]; j++) begin
				plan_time[i][j] = t;
				case (mode)
					0: nxt = t + 64'($urandom_range(2));
					1: nxt = t + {24'd0, 8'($urandom), 32'($urandom)};
					default: nxt = t + 64'($urandom_range(24'hFF_FFFF));
				endcase
				// saturate at the top of the time range
				if (nxt < t)
					nxt = '1;
				t = nxt;
			end
		end
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			ln = fill_order[i];
			fill_order[i] = fill_order[j];
			fill_order[j] = ln;
		end
		// first beat of every lane in shuffled order
		for (i = 0; i < n; i++)
			offer_lane(fill_order[i]);
		// refill whichever lane the block just emptied
		do begin
			best = -1;
			for (i = 0; i < n; i++) begin
				if (plan_pos[i] < plan_len[i]) begin
					if (best < 0)
						best = i;
					else if (plan_time[i][plan_pos[i]] < plan_time[best][plan_pos[best]])
						best = i;
				end
			end
			if (best >= 0) begin
				plan_pos[best]++;
				// stray beat to a lane that is holding, ended or out of range
				if ($urandom_range(7) == 0) begin
					do
						ln = $urandom_range(TB_LANES - 1);
					while (ln == best);
					push_item(1'($urandom), LANE_W'(ln), {$urandom, $urandom});
				end
				offer_lane(best);
			end
		end while (best >= 0);
	endtask

	// stimulus
	initial begin
		int phase;
		int n;
		int v;
		int start;
		int r;
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one lane after reset: extreme times, out-of-range lane, round done
		push_item(REQ_HEAD, 3'd0, '0);
		push_item(REQ_HEAD, 3'd0, '1);
		push_item(REQ_HEAD, 3'd5, 64'h1234_5678_9ABC_DEF0);
		push_item(REQ_END, 3'd0, '1);

		// three lanes: end and head while holding, head while ended, ties
		set_lane_count(3);
		push_item(REQ_HEAD, 3'd2, 64'd5);
		push_item(REQ_HEAD, 3'd0, 64'd5);
		push_item(REQ_END, 3'd0, '0);
		push_item(REQ_HEAD, 3'd0, 64'd1);
		push_item(REQ_END, 3'd1, '0);
		push_item(REQ_HEAD, 3'd1, '0);
		push_item(REQ_END, 3'd0, '0);
		push_item(REQ_HEAD, 3'd2, 64'h8000_0000_0000_0000);
		push_item(REQ_HEAD, 3'd7, '1);
		push_item(REQ_END, 3'd2, '0);
		push_item(REQ_HEAD, 3'd1, 64'hAAAA_AAAA_AAAA_AAAA);
		push_item(REQ_HEAD, 3'd0, 64'h5555_5555_5555_5555);
		push_item(REQ_HEAD, 3'd2, 64'h5555_5555_5555_5555);
		clear_lanes(3);

		// random phases, one lane-count setting and idle mix each
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			v = lane_settings[phase];
			set_lane_count(v);
			n = (v == 0) ? 1 : ((v > TB_LANES) ? TB_LANES : v);
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 57; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 57; end
				default: begin idle_pct = 29; stall_pct <= 29; end
			endcase
			if (phase == 4)
				hold_req <= 1'b1;
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				r = $urandom_range(9);
				if (r == 0) begin
					// broken traffic, then end lanes back to a clean round
					for (k = $urandom_range(12, 4); k > 0; k--)
						push_item(1'($urandom), LANE_W'($urandom_range(TB_LANES - 1)),
							($urandom_range(1) == 1) ? {$urandom, $urandom}
								: 64'($urandom_range(3)));
					clear_lanes(n);
				end else begin
					run_round(n);
					rounds++;
					if (r == 1)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d input beats, %0d planned merge rounds, %0d lane-count settings",
			items_sent, rounds, NUM_PHASES + 1);
		$display("idle mixes none, sender, receiver and both, plus a %0d-cycle result hold",
			LONG_HOLD);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
